// ===== src/rlvs_pkg.sv =====
package rlvs_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned ELAPSED_W     = 18;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIV_STEP_BITS = 4;

  // input beat layout
  localparam int unsigned GOAL_LSB    = 0;
  localparam int unsigned ELAPSED_LSB = VALUE_W;
  localparam int unsigned LOAD_LSB    = VALUE_W + ELAPSED_W;
  localparam int unsigned IN_DATA_W   = ((2 * VALUE_W + ELAPSED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = 2 * VALUE_W;

  // reset values: factor and limit are 4.0 in the chosen format
  localparam int unsigned TF_RESET_INT    = 4;
  localparam int unsigned SCL_RESET_INT   = 4;
  localparam int unsigned DROP_RATE_RESET = 164;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP       = 2'd0,
    CMD_LOAD_VALUE = 2'd1,
    CMD_LOAD_SPEED = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_FACTOR = 2'd0,
    REG_SPEED_LIMIT = 2'd1,
    REG_DROP_RATE   = 2'd2,
    REG_SMOOTHING   = 2'd3
  } cfg_idx_e;

endpackage

// ===== src/rlvs_div.sv =====
module rlvs_div #(
  parameter int unsigned NUM_W     = 52,
  parameter int unsigned DEN_W     = rlvs_pkg::ELAPSED_W,
  parameter int unsigned STEP_BITS = rlvs_pkg::DIV_STEP_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned NSTEPS = NUM_W / STEP_BITS;
  localparam int unsigned CNT_W  = $clog2(NSTEPS + 1);

  logic [NUM_W-1:0] acc_q, acc_d, step_acc;
  logic [DEN_W-1:0] rem_q, rem_d, step_rem;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // restoring division, STEP_BITS quotient bits per cycle
  always_comb begin : iterate
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] r;
    logic [NUM_W-1:0] a;
    r     = rem_q;
    a     = acc_q;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, a[NUM_W-1]};
      a     = {a[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        trial = trial - {1'b0, den_i};
        a[0]  = 1'b1;
      end
      r = trial[DEN_W-1:0];
    end
    step_rem = r;
    step_acc = a;
  end

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NSTEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = step_acc;
      rem_d = step_rem;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ===== src/rate_limited_value_smoother.sv =====
// Rate-limited value smoother. Each beat carries a command in tuser: a step moves the tracked
// value toward the goal (gap times the factor-elapsed product, capped at one, plus a drop term
// that never overshoots, with the speed change limited per second), the load commands set
// the value or the speed, and clear zeroes both. Values and speeds are signed fixed point with FRAC_BITS
// fraction bits, elapsed time is unsigned with FRAC_BITS fraction bits in 18 bits. One result
// beat per input beat, carrying the state after the item; the block takes one item at a time.
// Loads, clear and a step shorter than 1 ms go straight to the result; a step with smoothing
// off runs only the speed division, and a smoothing step runs one shared 4-bit-per-cycle
// divider twice and one shared multiplier up to six times. Configuration writes are taken
// at any time and must only be issued while idle.
module rate_limited_value_smoother #(
  parameter int unsigned FRAC_BITS = rlvs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rlvs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // goal, elapsed, load_data
  input  logic [rlvs_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rlvs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // current_value, current_speed
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rlvs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rlvs_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned VW     = rlvs_pkg::VALUE_W;
  localparam int unsigned EW     = rlvs_pkg::ELAPSED_W;
  localparam int unsigned CW     = rlvs_pkg::CFG_W;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned ONE    = 1 << F;
  localparam int unsigned MIN_EL = ((1 << F) + 999) / 1000;
  localparam int unsigned GW     = VW + 1;
  localparam int unsigned LW     = CW + EW - F;
  localparam int unsigned XW     = ((LW + 1 > 33) ? LW + 1 : 33) + 1;
  localparam int unsigned MAW    = 34;
  localparam int unsigned MBW    = ((EW > F + 1) ? EW : F + 1) + 1;
  localparam int unsigned MPW    = MAW + MBW;
  localparam int unsigned AW     = XW + EW + 2;
  localparam int unsigned AJ0    = AW - F + 1;
  localparam int unsigned AJ1    = (AJ0 > 34) ? AJ0 : 34;
  localparam int unsigned AJW    = (AJ1 > LW + 3) ? AJ1 : LW + 3;
  localparam int unsigned NW     = GW + F;
  localparam int unsigned NWP    = ((NW + rlvs_pkg::DIV_STEP_BITS - 1) /
                                    rlvs_pkg::DIV_STEP_BITS) * rlvs_pkg::DIV_STEP_BITS;
  localparam int unsigned QW     = NWP + 1;
  localparam int unsigned DFW    = QW + 1;
  localparam int unsigned CMW    = ((DFW > LW + 1) ? DFW : LW + 1) + 1;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_MFT   = 18'h00002,
    S_MDROP = 18'h00004,
    S_MLIM  = 18'h00008,
    S_MADJ  = 18'h00010,
    S_ADJ   = 18'h00020,
    S_DROP  = 18'h00040,
    S_DIV1  = 18'h00080,
    S_WAIT1 = 18'h00100,
    S_CMP   = 18'h00200,
    S_MXLO  = 18'h00400,
    S_MXHI  = 18'h00800,
    S_XSUM  = 18'h01000,
    S_XADJ  = 18'h02000,
    S_NEXT  = 18'h04000,
    S_DIV2  = 18'h08000,
    S_WAIT2 = 18'h10000,
    S_OUT   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic signed [VW-1:0]  tv_q, tv_d, cs_q, cs_d;
  logic [CW-1:0]         tf_q, tf_d, scl_q, scl_d, dr_q, dr_d;
  logic                  smooth_q, smooth_d;

  logic signed [GW-1:0]  gap_q, gap_d;
  logic [EW-1:0]         el_q, el_d;
  logic signed [VW-1:0]  next_q, next_d;
  logic [F:0]            ft_q, ft_d;
  logic [LW-1:0]         drop_q, drop_d, lim_q, lim_d;
  logic signed [MPW-1:0] prod_q;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic signed [AJW-1:0] adj_q, adj_d;
  logic signed [DFW-1:0] diff_q, diff_d;
  logic signed [XW-1:0]  x_q, x_d;
  logic                  neg_q, neg_d;

  logic                  in_acc;
  rlvs_pkg::cmd_e        cmd;
  logic signed [VW-1:0]  goal_in, load_in;
  logic [EW-1:0]         el_in;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;

  logic signed [MPW-1:0] prod_sh, prod_tr;
  logic signed [AW-1:0]  acc_tr;
  logic signed [AJW-1:0] gap_w, drop_w, adj_pl, adj_mi, adj_mag;
  logic signed [GW-1:0]  delta, delta_mag;
  logic signed [65:0]    xx;
  logic signed [MAW-1:0] x_lo, x_hi;
  logic signed [CMW-1:0] diff_c, lim_c;
  logic signed [XW-1:0]  cs_x, lim_x;
  logic signed [AJW:0]   nx_sum;
  logic signed [QW-1:0]  q_pos, q_s;

  logic                  div_start, div_done;
  logic [NWP-1:0]        div_num, div_quot;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cmd     = rlvs_pkg::cmd_e'(s_axis_tuser);
  assign goal_in = signed'(s_axis_tdata[rlvs_pkg::GOAL_LSB +: VW]);
  assign el_in   = s_axis_tdata[rlvs_pkg::ELAPSED_LSB +: EW];
  assign load_in = signed'(s_axis_tdata[rlvs_pkg::LOAD_LSB +: VW]);

  // shared multiplier
  always_comb begin
    mul_a = signed'(MAW'(tf_q));
    mul_b = signed'(MBW'(el_q));
    case (state_q)
      S_MDROP: mul_a = signed'(MAW'(dr_q));
      S_MLIM:  mul_a = signed'(MAW'(scl_q));
      S_MADJ: begin
        mul_a = MAW'(gap_q);
        mul_b = signed'(MBW'(ft_q));
      end
      S_MXLO:  mul_a = x_lo;
      S_MXHI:  mul_a = x_hi;
      default: mul_a = signed'(MAW'(tf_q));
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign prod_sh = prod_q >>> F;
  assign prod_tr = (prod_q + (prod_q[MPW-1] ? signed'(MPW'(ONE - 1))
                                            : signed'(MPW'(0)))) >>> F;
  assign acc_tr  = (acc_q + (acc_q[AW-1] ? signed'(AW'(ONE - 1))
                                         : signed'(AW'(0)))) >>> F;

  assign gap_w   = AJW'(gap_q);
  assign drop_w  = signed'(AJW'(drop_q));
  assign adj_pl  = adj_q + drop_w;
  assign adj_mi  = adj_q - drop_w;
  assign adj_mag = adj_q[AJW-1] ? -adj_q : adj_q;

  assign delta     = GW'(next_q) - GW'(tv_q);
  assign delta_mag = delta[GW-1] ? -delta : delta;

  assign xx   = 66'(x_q);
  assign x_lo = signed'({1'b0, xx[32:0]});
  assign x_hi = MAW'(signed'(xx[65:33]));

  assign diff_c = CMW'(diff_q);
  assign lim_c  = signed'(CMW'(lim_q));
  assign cs_x   = XW'(cs_q);
  assign lim_x  = signed'(XW'(lim_q));
  assign nx_sum = (AJW + 1)'(adj_q) + (AJW + 1)'(tv_q);

  assign q_pos = signed'({1'b0, div_quot});
  assign q_s   = neg_q ? -q_pos : q_pos;

  assign div_start = (state_q == S_DIV1) || (state_q == S_DIV2);
  assign div_num   = (state_q == S_DIV2) ? NWP'({delta_mag[GW-1:0], {F{1'b0}}})
                                         : NWP'({adj_mag[GW-1:0], {F{1'b0}}});

  rlvs_div #(
    .NUM_W     (NWP),
    .DEN_W     (EW),
    .STEP_BITS (rlvs_pkg::DIV_STEP_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (el_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d  = state_q;
    tv_d     = tv_q;
    cs_d     = cs_q;
    tf_d     = tf_q;
    scl_d    = scl_q;
    dr_d     = dr_q;
    smooth_d = smooth_q;
    gap_d    = gap_q;
    el_d     = el_q;
    next_d   = next_q;
    ft_d     = ft_q;
    drop_d   = drop_q;
    lim_d    = lim_q;
    acc_d    = acc_q;
    adj_d    = adj_q;
    diff_d   = diff_q;
    x_d      = x_q;
    neg_d    = neg_q;

    if (cfg_valid_i) begin
      case (rlvs_pkg::cfg_idx_e'(cfg_index_i))
        rlvs_pkg::REG_TIME_FACTOR: tf_d     = cfg_data_i;
        rlvs_pkg::REG_SPEED_LIMIT: scl_d    = cfg_data_i;
        rlvs_pkg::REG_DROP_RATE:   dr_d     = cfg_data_i;
        rlvs_pkg::REG_SMOOTHING:   smooth_d = cfg_data_i[0];
        default:                   tf_d     = tf_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          el_d    = el_in;
          gap_d   = GW'(goal_in) - GW'(tv_q);
          next_d  = goal_in;
          state_d = S_OUT;
          case (cmd)
            rlvs_pkg::CMD_LOAD_VALUE: tv_d = load_in;
            rlvs_pkg::CMD_LOAD_SPEED: cs_d = load_in;
            rlvs_pkg::CMD_CLEAR: begin
              tv_d = '0;
              cs_d = '0;
            end
            default: begin
              if (el_in >= EW'(MIN_EL)) begin
                state_d = smooth_q ? S_MFT : S_DIV2;
              end
            end
          endcase
        end
      end
      S_MFT:   state_d = S_MDROP;
      S_MDROP: begin
        ft_d    = (prod_sh > MPW'(ONE)) ? (F + 1)'(ONE) : prod_sh[F:0];
        state_d = S_MLIM;
      end
      S_MLIM: begin
        drop_d  = LW'(prod_sh);
        state_d = S_MADJ;
      end
      S_MADJ: begin
        lim_d   = LW'(prod_sh);
        state_d = S_ADJ;
      end
      S_ADJ: begin
        adj_d   = AJW'(prod_tr);
        state_d = S_DROP;
      end
      S_DROP: begin
        // drop term toward the goal, never past it
        if (gap_q > 0) begin
          adj_d = (adj_pl > gap_w) ? gap_w : adj_pl;
        end else begin
          adj_d = (adj_mi < gap_w) ? gap_w : adj_mi;
        end
        state_d = S_DIV1;
      end
      S_DIV1: begin
        neg_d   = adj_q[AJW-1];
        state_d = S_WAIT1;
      end
      S_WAIT1: begin
        if (div_done) begin
          diff_d  = DFW'(q_s) - DFW'(cs_q);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_NEXT;
        if (diff_c > lim_c && gap_q > 0) begin
          x_d     = cs_x + lim_x;
          state_d = S_MXLO;
        end else if (diff_c < -lim_c && gap_q < 0) begin
          x_d     = cs_x - lim_x;
          state_d = S_MXLO;
        end
      end
      S_MXLO:  state_d = S_MXHI;
      S_MXHI: begin
        acc_d   = AW'(prod_q);
        state_d = S_XSUM;
      end
      S_XSUM: begin
        acc_d   = acc_q + (AW'(prod_q) <<< 33);
        state_d = S_XADJ;
      end
      S_XADJ: begin
        adj_d   = AJW'(acc_tr);
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (nx_sum > (AJW + 1)'(VMAX)) begin
          next_d = VMAX;
        end else if (nx_sum < (AJW + 1)'(VMIN)) begin
          next_d = VMIN;
        end else begin
          next_d = VW'(nx_sum);
        end
        state_d = S_DIV2;
      end
      S_DIV2: begin
        neg_d   = delta[GW-1];
        state_d = S_WAIT2;
      end
      S_WAIT2: begin
        if (div_done) begin
          if (q_s > QW'(VMAX)) begin
            cs_d = VMAX;
          end else if (q_s < QW'(VMIN)) begin
            cs_d = VMIN;
          end else begin
            cs_d = VW'(q_s);
          end
          tv_d    = next_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tv_q     <= '0;
      cs_q     <= '0;
      tf_q     <= CW'(rlvs_pkg::TF_RESET_INT << F);
      scl_q    <= CW'(rlvs_pkg::SCL_RESET_INT << F);
      dr_q     <= CW'(rlvs_pkg::DROP_RATE_RESET);
      smooth_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      tv_q     <= tv_d;
      cs_q     <= cs_d;
      tf_q     <= tf_d;
      scl_q    <= scl_d;
      dr_q     <= dr_d;
      smooth_q <= smooth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q  <= gap_d;
    el_q   <= el_d;
    next_q <= next_d;
    ft_q   <= ft_d;
    drop_q <= drop_d;
    lim_q  <= lim_d;
    prod_q <= mul_p;
    acc_q  <= acc_d;
    adj_q  <= adj_d;
    diff_q <= diff_d;
    x_q    <= x_d;
    neg_q  <= neg_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {cs_q, tv_q};
  assign cfg_ready_o   = 1'b1;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == rlvs_pkg::CMD_LOAD_VALUE)
      |=> (m_axis_tvalid && tv_q == $past(load_in)))
    else $error("load value not applied");

  a_short_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == rlvs_pkg::CMD_STEP && el_in < EW'(MIN_EL))
      |=> (m_axis_tvalid && $stable(tv_q) && $stable(cs_q)))
    else $error("short step changed state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT1 || state_q == S_WAIT2))
    else $error("divider finished outside a wait state");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int     FRAC        = rlvs_pkg::FRAC_BITS_DEF;
  localparam longint ONE         = longint'(1) << FRAC;
  localparam longint MIN_EL      = ((longint'(1) << FRAC) + 999) / 1000;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -S32_MAX - 1;
  localparam int     PAD_W       = rlvs_pkg::IN_DATA_W - 2 * rlvs_pkg::VALUE_W -
                                   rlvs_pkg::ELAPSED_W;
  localparam int     N_PHASES    = 8;
  localparam int     PHASE_ITEMS = 66;
  localparam int     HOLD_AT     = 150;
  localparam int     HOLD_CYCLES = 400;
  localparam int     DRAIN       = 60;
  localparam int     IDLE_LIMIT  = 3000;

  localparam rlvs_pkg::cmd_e C_STEP = rlvs_pkg::CMD_STEP;
  localparam rlvs_pkg::cmd_e C_LDV  = rlvs_pkg::CMD_LOAD_VALUE;
  localparam rlvs_pkg::cmd_e C_LDS  = rlvs_pkg::CMD_LOAD_SPEED;
  localparam rlvs_pkg::cmd_e C_CLR  = rlvs_pkg::CMD_CLEAR;

  typedef struct packed {
    rlvs_pkg::cmd_e cmd;
    logic [31:0]    goal;
    logic [17:0]    el;
    logic [31:0]    ld;
    logic           typed;
    logic [31:0]    exp_val;
    logic [31:0]    exp_spd;
  } row_t;

  typedef struct packed {
    logic [31:0] val;
    logic [31:0] spd;
  } smoothed_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [rlvs_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [rlvs_pkg::CMD_W-1:0]      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [rlvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [rlvs_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [rlvs_pkg::CFG_W-1:0]      cfg_data_i;

  rate_limited_value_smoother u_top (.*);

  // tracker copy and its settings
  longint    trk_val = 0;
  longint    trk_spd = 0;
  longint    set_factor = 262144;
  longint    set_limit = 262144;
  longint    set_drop = 164;
  bit        set_smooth = 1'b1;
  smoothed_t pending_q[$];
  int        n_errors = 0;
  int        n_in = 0;
  bit        quiet = 1'b0;

  localparam row_t DIRECTED [0:20] = '{
    '{C_STEP, 32'h7FFF_FFFF, 18'd0,      32'h0,         1'b1, 32'h0,         32'h0},
    '{C_STEP, 32'h8000_0000, 18'd65,     32'h0,         1'b1, 32'h0,         32'h0},
    '{C_LDV,  32'hFFFF_FFFF, 18'h3FFFF,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h0},
    '{C_LDS,  32'h0,         18'h3FFFF,  32'h8000_0000, 1'b1, 32'h7FFF_FFFF,
      32'h8000_0000},
    '{C_STEP, 32'h8000_0000, 18'd66,     32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h8000_0000, 18'h3FFFF,  32'h0,         1'b0, 32'h0,         32'h0},
    '{C_CLR,  32'h1234_5678, 18'h3FFFF,  32'hDEAD_BEEF, 1'b1, 32'h0,         32'h0},
    '{C_STEP, 32'h7FFF_FFFF, 18'd66,     32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h7FFF_FFFF, 18'h3FFFF,  32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h7FFF_FFFF, 18'h10000,  32'h0,         1'b0, 32'h0,         32'h0},
    '{C_CLR,  32'h0,         18'h0,      32'h0,         1'b1, 32'h0,         32'h0},
    '{C_LDV,  32'h0,         18'h0,      32'h8000_0000, 1'b1, 32'h8000_0000, 32'h0},
    '{C_LDS,  32'h0,         18'h0,      32'h7FFF_FFFF, 1'b1, 32'h8000_0000,
      32'h7FFF_FFFF},
    '{C_STEP, 32'h7FFF_FFFF, 18'd66,     32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h7FFF_FFFF, 18'h1000,   32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h7FFF_FFFF, 18'h1000,   32'h0,         1'b0, 32'h0,         32'h0},
    '{C_LDV,  32'h0,         18'h0,      32'h0001_0000, 1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h0001_0000, 18'h4000,   32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'hFFFF_0000, 18'h4000,   32'h0,         1'b0, 32'h0,         32'h0},
    '{C_LDS,  32'h0,         18'h0,      32'h0,         1'b0, 32'h0,         32'h0},
    '{C_STEP, 32'h0,         18'h20000,  32'h0,         1'b0, 32'h0,         32'h0}
  };

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic longint sat32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // shift out the fraction, rounding toward zero
  function automatic longint drop_frac(longint x);
    if (x < 0) return -((-x) >>> FRAC);
    return x >>> FRAC;
  endfunction

  function automatic void advance_tracker(rlvs_pkg::cmd_e cmd, logic [31:0] goal_raw,
                                          logic [17:0] el_raw, logic [31:0] ld_raw);
    longint goal, e, ftu, ft, gap, adj, drop, lim, diff, nxt;
    goal = longint'($signed(goal_raw));
    e    = longint'(el_raw);
    case (cmd)
      rlvs_pkg::CMD_LOAD_VALUE: trk_val = longint'($signed(ld_raw));
      rlvs_pkg::CMD_LOAD_SPEED: trk_spd = longint'($signed(ld_raw));
      rlvs_pkg::CMD_CLEAR: begin
        trk_val = 0;
        trk_spd = 0;
      end
      default: begin
        if (e >= MIN_EL) begin
          if (set_smooth) begin
            ftu  = (e * set_factor) >>> FRAC;
            ft   = (ftu > ONE) ? ONE : ftu;
            gap  = goal - trk_val;
            adj  = drop_frac(gap * ft);
            drop = (set_drop * e) >>> FRAC;
            lim  = (set_limit * e) >>> FRAC;
            if (gap > 0) begin
              adj += drop;
              if (adj > gap) adj = gap;
            end else begin
              adj -= drop;
              if (adj < gap) adj = gap;
            end
            diff = (adj * ONE) / e - trk_spd;
            if (diff > lim && trk_val < goal) adj = drop_frac((trk_spd + lim) * e);
            else if (diff < -lim && trk_val > goal) adj = drop_frac((trk_spd - lim) * e);
            nxt = sat32(trk_val + adj);
          end else begin
            nxt = goal;
          end
          trk_spd = sat32(((nxt - trk_val) * ONE) / e);
          trk_val = nxt;
        end
      end
    endcase
  endfunction

  task automatic write_reg(rlvs_pkg::cfg_idx_e idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rlvs_pkg::REG_TIME_FACTOR: set_factor = longint'(d);
      rlvs_pkg::REG_SPEED_LIMIT: set_limit  = longint'(d);
      rlvs_pkg::REG_DROP_RATE:   set_drop   = longint'(d);
      default:                   set_smooth = d[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer_item(row_t r);
    int        gap;
    smoothed_t exp;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {{PAD_W{1'b0}}, r.ld, r.el, r.goal};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_tracker(r.cmd, r.goal, r.el, r.ld);
    if (r.typed) exp = '{r.exp_val, r.exp_spd};
    else exp = '{trk_val[31:0], trk_spd[31:0]};
    pending_q.push_back(exp);
    n_in++;
  endtask

  task automatic drain_phase();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic row_t random_item();
    row_t r;
    int   pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 74) r.cmd = rlvs_pkg::CMD_STEP;
    else if (pick < 86) r.cmd = rlvs_pkg::CMD_LOAD_VALUE;
    else if (pick < 95) r.cmd = rlvs_pkg::CMD_LOAD_SPEED;
    else r.cmd = rlvs_pkg::CMD_CLEAR;
    case ($urandom_range(0, 3))
      0: r.goal = $urandom;
      1: r.goal = 32'(trk_val + longint'($urandom_range(0, 32'h3FFFF)) - 64'sh20000);
      default: r.goal = 32'(longint'($urandom_range(0, 32'hFFFFF)) - 64'sh80000);
    endcase
    case ($urandom_range(0, 4))
      0: r.el = 18'($urandom_range(0, 65));
      1: r.el = 18'($urandom_range(0, 18'h3FFFF));
      2: r.el = 18'($urandom_range(66, 4000));
      default: r.el = 18'($urandom_range(66, 18'h3000));
    endcase
    if ($urandom_range(0, 1) == 0) r.ld = $urandom;
    else r.ld = 32'(longint'($urandom_range(0, 32'h7FFFF)) - 64'sh40000);
    return r;
  endfunction

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin : result_sink
    bit hold_done;
    int stall;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_in >= HOLD_AT) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 8);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    smoothed_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        $error("unexpected result beat: current_value %0d current_speed %0d",
               $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
      end else begin
        exp = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== exp.val) begin
          n_errors++;
          $error("current_value: expected %0d, got %0d", $signed(exp.val),
                 $signed(m_axis_tdata[31:0]));
        end
        if (m_axis_tdata[63:32] !== exp.spd) begin
          n_errors++;
          $error("current_speed: expected %0d, got %0d", $signed(exp.spd),
                 $signed(m_axis_tdata[63:32]));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int p, i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rlvs_pkg::CMD_STEP;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = rlvs_pkg::REG_TIME_FACTOR;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[k]) offer_item(DIRECTED[k]);
    drain_phase();

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(rlvs_pkg::REG_TIME_FACTOR, 32'h0);
          write_reg(rlvs_pkg::REG_SPEED_LIMIT, 32'h0);
          write_reg(rlvs_pkg::REG_DROP_RATE, 32'h0);
          write_reg(rlvs_pkg::REG_SMOOTHING, 32'h1);
        end
        1: begin
          write_reg(rlvs_pkg::REG_TIME_FACTOR, 32'hFFFF_FFFF);
          write_reg(rlvs_pkg::REG_SPEED_LIMIT, 32'hFFFF_FFFF);
          write_reg(rlvs_pkg::REG_DROP_RATE, 32'hFFFF_FFFF);
          write_reg(rlvs_pkg::REG_SMOOTHING, 32'h1);
        end
        2: begin
          write_reg(rlvs_pkg::REG_TIME_FACTOR, $urandom);
          write_reg(rlvs_pkg::REG_SPEED_LIMIT, $urandom);
          write_reg(rlvs_pkg::REG_DROP_RATE, $urandom);
          write_reg(rlvs_pkg::REG_SMOOTHING, 32'h0);
        end
        default: begin
          write_reg(rlvs_pkg::REG_TIME_FACTOR, $urandom_range(0, 32'h000A_0000));
          write_reg(rlvs_pkg::REG_SPEED_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom :
                                               $urandom_range(0, 32'h0010_0000));
          write_reg(rlvs_pkg::REG_DROP_RATE, $urandom_range(0, 32'h0010_0000));
          write_reg(rlvs_pkg::REG_SMOOTHING, ($urandom_range(0, 4) != 0) ? 32'h1 : 32'h0);
        end
      endcase
      quiet = (p == N_PHASES - 1);
      for (i = 0; i < PHASE_ITEMS; i++) offer_item(random_item());
      drain_phase();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
